FILE: hdl/fdc_pkg.sv
package fdc_pkg;

  localparam int DutyW    = 10;
  localparam int TimeW    = 32;
  localparam int TempW    = 13;
  localparam int CfgTempW = 12;
  localparam int KickMsW  = 16;
  localparam int SlewW    = 8;

  // signed width that holds every temperature reading and threshold
  localparam int CmpW     = TempW + 1;
  // signed width for duty arithmetic around the limits
  localparam int SumW     = DutyW + 2;

  localparam int MulAW    = 14;
  localparam int MulBW    = DutyW;
  localparam int ProdW    = MulAW + MulBW;
  localparam int DivNumW  = ProdW + 1;
  localparam int DivDenW  = 15;
  localparam int DivCntW  = $clog2(DivNumW + 1);

  // ramp quotient (prod + 5000) / 10000 as (((prod + 5000) >> 4) * ceil(2^30 / 625)) >> 30
  localparam int RampDrop  = 4;
  localparam int RampXW    = ProdW - RampDrop;
  localparam int RecipW    = 21;
  localparam int RampShift = 30;
  localparam int RampPW    = RampXW + RecipW;

  localparam int ApbAddrW = 5;
  localparam int ApbDataW = 32;

  localparam logic [TimeW-1:0] SeqDelayMs = TimeW'(5000);
  localparam logic [TimeW-1:0] SeqTotalMs = TimeW'(15000);
  localparam logic [ProdW-1:0]  RampBias  = ProdW'(5000);
  localparam logic [RecipW-1:0] RampRecip = RecipW'(1717987);

  localparam logic signed [CmpW-1:0] TempLowest  = -CmpW'(880);
  localparam logic signed [CmpW-1:0] TempHighest = CmpW'(2000);

  typedef enum logic [2:0] {
    REG_TEMP_FULL,
    REG_TEMP_TURN_ON,
    REG_TEMP_TURN_OFF,
    REG_MIN_DUTY,
    REG_MAX_DUTY,
    REG_KICK_DUTY,
    REG_KICK_MS,
    REG_SLEW_STEP
  } reg_idx_e;

  typedef struct packed {
    logic signed [CfgTempW-1:0] temp_full;
    logic signed [CfgTempW-1:0] temp_turn_on;
    logic signed [CfgTempW-1:0] temp_turn_off;
    logic [DutyW-1:0]           min_duty;
    logic [DutyW-1:0]           max_duty;
    logic [DutyW-1:0]           kick_duty;
    logic [KickMsW-1:0]         kick_ms;
    logic [SlewW-1:0]           slew_step;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic mul;
    logic div_start;
    logic target;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_mul;
    logic needs_div;
    logic div_busy;
  } ctrl_sts_t;

endpackage

FILE: hdl/fdc_regs.sv
module fdc_regs import fdc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_full     <= CfgTempW'(960);
      cfg_q.temp_turn_on  <= CfgTempW'(640);
      cfg_q.temp_turn_off <= CfgTempW'(560);
      cfg_q.min_duty      <= DutyW'(300);
      cfg_q.max_duty      <= DutyW'(1023);
      cfg_q.kick_duty     <= DutyW'(1023);
      cfg_q.kick_ms       <= KickMsW'(500);
      cfg_q.slew_step     <= SlewW'(5);
    end else if (wr_en) begin
      case (idx)
        REG_TEMP_FULL:     cfg_q.temp_full     <= pwdata[CfgTempW-1:0];
        REG_TEMP_TURN_ON:  cfg_q.temp_turn_on  <= pwdata[CfgTempW-1:0];
        REG_TEMP_TURN_OFF: cfg_q.temp_turn_off <= pwdata[CfgTempW-1:0];
        REG_MIN_DUTY:      cfg_q.min_duty      <= pwdata[DutyW-1:0];
        REG_MAX_DUTY:      cfg_q.max_duty      <= pwdata[DutyW-1:0];
        REG_KICK_DUTY:     cfg_q.kick_duty     <= pwdata[DutyW-1:0];
        REG_KICK_MS:       cfg_q.kick_ms       <= pwdata[KickMsW-1:0];
        REG_SLEW_STEP:     cfg_q.slew_step     <= pwdata[SlewW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TEMP_FULL:     prdata = ApbDataW'(unsigned'(cfg_q.temp_full));
      REG_TEMP_TURN_ON:  prdata = ApbDataW'(unsigned'(cfg_q.temp_turn_on));
      REG_TEMP_TURN_OFF: prdata = ApbDataW'(unsigned'(cfg_q.temp_turn_off));
      REG_MIN_DUTY:      prdata = ApbDataW'(cfg_q.min_duty);
      REG_MAX_DUTY:      prdata = ApbDataW'(cfg_q.max_duty);
      REG_KICK_DUTY:     prdata = ApbDataW'(cfg_q.kick_duty);
      REG_KICK_MS:       prdata = ApbDataW'(cfg_q.kick_ms);
      REG_SLEW_STEP:     prdata = ApbDataW'(cfg_q.slew_step);
      default:           prdata = '0;
    endcase
  end

endmodule

FILE: hdl/fdc_div.sv
module fdc_div import fdc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] dividend_i,
  input  logic [DivDenW-1:0] divisor_i,
  output logic               busy_o,
  output logic [DivNumW-1:0] quotient_o
);

  logic [DivDenW-1:0] rem_q, rem_d, den_q;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [DivDenW:0]   shifted, diff;
  logic               ge;

  // one restoring step per cycle, quotient bits shift in from the right
  always_comb begin
    shifted = {rem_q, quo_q[DivNumW-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = DivCntW'(DivNumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? diff[DivDenW-1:0] : shifted[DivDenW-1:0];
      quo_d  = {quo_q[DivNumW-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != DivCntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("divider did not go busy after start");

endmodule

FILE: hdl/fdc_datapath.sv
module fdc_datapath import fdc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_cmd_t               cmd_i,
  output ctrl_sts_t               sts_o,
  input  cfg_t                    cfg_i,
  input  logic                    command_i,
  input  logic [TimeW-1:0]        now_ms_i,
  input  logic signed [TempW-1:0] temp_sixteenths_i,
  input  logic                    reading_valid_i,
  output logic [DutyW-1:0]        duty_o,
  output logic                    fan_running_o,
  output logic                    kicking_o,
  output logic                    powering_on_o
);

  typedef enum logic [2:0] {
    PATH_RESTART,
    PATH_BAD,
    PATH_HOLD,
    PATH_RAMP,
    PATH_RUN
  } path_e;

  typedef enum logic [1:0] {
    REGION_FULL,
    REGION_OFF,
    REGION_PROP,
    REGION_BAND
  } region_e;

  // captured transaction
  logic                    cmd_q;
  logic [TimeW-1:0]        now_q;
  logic signed [TempW-1:0] temp_q;
  logic                    rvalid_q;

  // controller state
  logic [DutyW-1:0] duty_q, duty_d;
  logic             fan_q, fan_d;
  logic             kick_pend_q, kick_pend_d;
  logic [TimeW-1:0] kick_began_q, kick_began_d;
  logic             seq_act_q, seq_act_d;
  logic [TimeW-1:0] seq_began_q, seq_began_d;
  logic             kicking_q, kicking_d;

  // evaluation results
  path_e                kind_d, kind_q;
  region_e              region_d, region_q;
  logic                 fan_eff_d, fan_eff_q;
  logic                 kp_eff_d, kp_eff_q;
  logic                 kick_live_d, kick_live_q;
  logic [MulAW-1:0]     ramp_x_q;
  logic [CfgTempW-1:0]  num_q, span_q;
  logic [DutyW-1:0]     mag_d, mag_q;
  logic                 dneg_q;

  logic signed [CmpW-1:0] t_ext, full_ext, on_ext, off_ext, num_ext, span_ext;
  logic [TimeW-1:0]       seq_el, kick_el;
  logic                   bad;
  logic signed [DutyW:0]  d_span;

  logic [MulAW-1:0]   mul_a;
  logic [MulBW-1:0]   mul_b;
  logic [ProdW-1:0]   prod_q;
  logic [DivNumW-1:0] dividend;
  logic [DivDenW-1:0] divisor;
  logic [DivNumW-1:0] quot;
  logic [DutyW-1:0]   q;
  logic               div_busy;
  logic               use_div;

  logic [ProdW-1:0]   ramp_n;
  logic [RampPW-1:0]  ramp_p_q;
  logic [DutyW-1:0]   ramp_q;

  logic signed [SumW-1:0] min_s, max_s, q_s, v_s;
  logic [DutyW-1:0]       prop_tgt, target_d, target_q;

  logic                   turn_on, turn_off, kick_now;
  logic [SumW-1:0]        up_sum;
  logic signed [SumW-1:0] dn_v, tgt_s;
  logic [DutyW-1:0]       up_duty, dn_duty, slewed;

  // classify the captured transaction
  always_comb begin
    t_ext    = CmpW'(temp_q);
    full_ext = CmpW'(cfg_i.temp_full);
    on_ext   = CmpW'(cfg_i.temp_turn_on);
    off_ext  = CmpW'(cfg_i.temp_turn_off);
    num_ext  = t_ext - on_ext;
    span_ext = full_ext - on_ext;
    seq_el   = now_q - seq_began_q;
    kick_el  = now_q - kick_began_q;
    bad      = !rvalid_q || (t_ext < TempLowest) || (t_ext > TempHighest);

    if (!cmd_q) begin
      kind_d = PATH_RESTART;
    end else if (bad) begin
      kind_d = PATH_BAD;
    end else if (seq_act_q && (seq_el < SeqDelayMs)) begin
      kind_d = PATH_HOLD;
    end else if (seq_act_q && (seq_el < SeqTotalMs)) begin
      kind_d = PATH_RAMP;
    end else begin
      kind_d = PATH_RUN;
    end

    if (t_ext >= full_ext) begin
      region_d = REGION_FULL;
    end else if (t_ext <= off_ext) begin
      region_d = REGION_OFF;
    end else if (t_ext >= on_ext) begin
      region_d = REGION_PROP;
    end else begin
      region_d = REGION_BAND;
    end

    // a sequence that ends on this transaction drops the fan and kick state first
    fan_eff_d   = seq_act_q ? 1'b0 : fan_q;
    kp_eff_d    = seq_act_q ? 1'b0 : kick_pend_q;
    kick_live_d = kp_eff_d && (kick_el < TimeW'(cfg_i.kick_ms));

    d_span = $signed({1'b0, cfg_i.max_duty}) - $signed({1'b0, cfg_i.min_duty});
    mag_d  = d_span[DutyW] ? DutyW'(-d_span) : d_span[DutyW-1:0];
  end

  assign sts_o.needs_mul = (kind_d == PATH_RAMP) ||
                           ((kind_d == PATH_RUN) && (region_d == REGION_PROP));
  assign use_div         = (kind_q == PATH_RUN) && (region_q == REGION_PROP);
  assign sts_o.needs_div = use_div;
  assign sts_o.div_busy  = div_busy;

  // shared multiplier, divider for the temperature span only
  assign mul_a = (kind_q == PATH_RAMP) ? ramp_x_q : MulAW'(num_q);
  assign mul_b = (kind_q == PATH_RAMP) ? cfg_i.max_duty : mag_q;

  assign dividend = {prod_q, 1'b0} + DivNumW'(span_q);
  assign divisor  = DivDenW'({span_q, 1'b0});

  fdc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start & use_div),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  assign q = quot[DutyW-1:0];

  // ramp division by a constant through a reciprocal product
  assign ramp_n = prod_q + RampBias;
  assign ramp_q = ramp_p_q[RampShift +: DutyW];

  // target duty from the temperature curve
  always_comb begin
    min_s = $signed(SumW'(cfg_i.min_duty));
    max_s = $signed(SumW'(cfg_i.max_duty));
    q_s   = $signed(SumW'(q));
    v_s   = dneg_q ? (min_s - q_s) : (min_s + q_s);
    if (v_s < min_s) begin
      prop_tgt = cfg_i.min_duty;
    end else if (v_s > max_s) begin
      prop_tgt = cfg_i.max_duty;
    end else begin
      prop_tgt = v_s[DutyW-1:0];
    end
    case (region_q)
      REGION_FULL: target_d = cfg_i.max_duty;
      REGION_OFF:  target_d = '0;
      REGION_PROP: target_d = prop_tgt;
      REGION_BAND: target_d = fan_eff_q ? cfg_i.min_duty : '0;
      default:     target_d = '0;
    endcase
  end

  // fan, kick and slew update
  always_comb begin
    turn_on  = (target_q != '0) && !fan_eff_q;
    turn_off = (target_q == '0);
    kick_now = turn_on ? (cfg_i.kick_ms != '0) : (!turn_off && kick_live_q);

    up_sum  = SumW'(duty_q) + SumW'(cfg_i.slew_step);
    up_duty = (up_sum > SumW'(target_q)) ? target_q : up_sum[DutyW-1:0];

    dn_v  = $signed(SumW'(duty_q)) - $signed(SumW'(cfg_i.slew_step));
    tgt_s = $signed(SumW'(target_q));
    if (dn_v < tgt_s) begin
      dn_duty = target_q;
    end else if (dn_v > $signed(SumW'(cfg_i.max_duty))) begin
      dn_duty = cfg_i.max_duty;
    end else begin
      dn_duty = dn_v[DutyW-1:0];
    end

    if (duty_q < target_q) begin
      slewed = up_duty;
    end else if (duty_q > target_q) begin
      slewed = dn_duty;
    end else begin
      slewed = duty_q;
    end
  end

  always_comb begin
    duty_d       = duty_q;
    fan_d        = fan_q;
    kick_pend_d  = kick_pend_q;
    kick_began_d = kick_began_q;
    seq_act_d    = seq_act_q;
    seq_began_d  = seq_began_q;
    kicking_d    = 1'b0;
    case (kind_q)
      PATH_RESTART: begin
        seq_act_d   = 1'b1;
        seq_began_d = now_q;
        duty_d      = '0;
        fan_d       = 1'b0;
        kick_pend_d = 1'b0;
      end
      PATH_BAD: begin
        if (!seq_act_q) begin
          duty_d = '0;
        end
      end
      PATH_HOLD: duty_d = '0;
      PATH_RAMP: duty_d = ramp_q;
      PATH_RUN: begin
        seq_act_d = 1'b0;
        if (turn_on) begin
          fan_d        = 1'b1;
          kick_pend_d  = 1'b1;
          kick_began_d = now_q;
        end else if (turn_off) begin
          fan_d       = 1'b0;
          kick_pend_d = 1'b0;
        end else begin
          fan_d       = fan_eff_q;
          kick_pend_d = kp_eff_q;
        end
        kicking_d = kick_now;
        duty_d    = kick_now ? cfg_i.kick_duty : slewed;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q       <= '0;
      fan_q        <= 1'b0;
      kick_pend_q  <= 1'b0;
      kick_began_q <= '0;
      seq_act_q    <= 1'b1;
      seq_began_q  <= '0;
      kicking_q    <= 1'b0;
    end else if (cmd_i.commit) begin
      duty_q       <= duty_d;
      fan_q        <= fan_d;
      kick_pend_q  <= kick_pend_d;
      kick_began_q <= kick_began_d;
      seq_act_q    <= seq_act_d;
      seq_began_q  <= seq_began_d;
      kicking_q    <= kicking_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= command_i;
      now_q    <= now_ms_i;
      temp_q   <= temp_sixteenths_i;
      rvalid_q <= reading_valid_i;
    end
    if (cmd_i.eval) begin
      kind_q      <= kind_d;
      region_q    <= region_d;
      fan_eff_q   <= fan_eff_d;
      kp_eff_q    <= kp_eff_d;
      kick_live_q <= kick_live_d;
      ramp_x_q    <= seq_el[MulAW-1:0] - SeqDelayMs[MulAW-1:0];
      num_q       <= num_ext[CfgTempW-1:0];
      span_q      <= span_ext[CfgTempW-1:0];
      mag_q       <= mag_d;
      dneg_q      <= d_span[DutyW];
    end
    if (cmd_i.mul) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.div_start) begin
      ramp_p_q <= ramp_n[ProdW-1:RampDrop] * RampRecip;
    end
    if (cmd_i.target) begin
      target_q <= target_d;
    end
  end

  assign duty_o        = duty_q;
  assign fan_running_o = fan_q;
  assign kicking_o     = kicking_q;
  assign powering_on_o = seq_act_q;

endmodule

FILE: hdl/fdc_ctrl.sv
module fdc_ctrl import fdc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DLOAD,
    S_DIV,
    S_TARGET,
    S_APPLY
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, in_ready_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    in_ready_d  = in_ready_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.capture = 1'b1;
          in_ready_d    = 1'b0;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.needs_mul ? S_MUL : S_TARGET;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DLOAD;
      end
      S_DLOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = sts_i.needs_div ? S_DIV : S_TARGET;
      end
      S_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = S_TARGET;
        end
      end
      S_TARGET: begin
        cmd_o.target = 1'b1;
        state_d      = S_APPLY;
      end
      S_APPLY: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          in_ready_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= in_ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("result committed over an unaccepted transaction");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("committed result not presented");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_q == (state_q == S_IDLE))
    else $error("input ready out of step with controller state");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DLOAD) && sts_i.needs_div) |=> sts_i.div_busy)
    else $error("divider not running after load");

endmodule

FILE: hdl/fan_duty_controller_core.sv
// A result is registered after the evaluate, target and apply states; the power-on ramp adds
// the multiply and divider-load states, and the proportional curve also waits in the divide
// state for the 25-step serial divider, which divides by the configured temperature span.
// Apply holds until the previous result is accepted; one transaction is in flight at a time.
// Reset (rst_ni low, asynchronous): duty 0, fan off, power-on sequence active from time 0,
// configuration back to its defaults, no result pending.
module fan_duty_controller_core import fdc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrW-1:0]     paddr,
  input  logic [ApbDataW-1:0]     pwdata,
  output logic [ApbDataW-1:0]     prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    command_i,
  input  logic [TimeW-1:0]        now_ms_i,
  input  logic signed [TempW-1:0] temp_sixteenths_i,
  input  logic                    reading_valid_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DutyW-1:0]        duty_o,
  output logic                    fan_running_o,
  output logic                    kicking_o,
  output logic                    powering_on_o
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  fdc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fdc_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_i             (cfg),
    .command_i         (command_i),
    .now_ms_i          (now_ms_i),
    .temp_sixteenths_i (temp_sixteenths_i),
    .reading_valid_i   (reading_valid_i),
    .duty_o            (duty_o),
    .fan_running_o     (fan_running_o),
    .kicking_o         (kicking_o),
    .powering_on_o     (powering_on_o)
  );

endmodule

FILE: sim/fan_duty_checker.sv
module fan_duty_checker import fdc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel_i,
  input  logic                    penable_i,
  input  logic                    pwrite_i,
  input  logic                    pready_i,
  input  logic [ApbAddrW-1:0]     paddr_i,
  input  logic [ApbDataW-1:0]     pwdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    command_i,
  input  logic [TimeW-1:0]        now_ms_i,
  input  logic signed [TempW-1:0] temp_sixteenths_i,
  input  logic                    reading_valid_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [DutyW-1:0]        duty_i,
  input  logic                    fan_running_i,
  input  logic                    kicking_i,
  input  logic                    powering_on_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             fan_running;
    logic             kicking;
    logic             powering_on;
  } fan_result_t;

  fan_result_t duty_expected_q[$];
  cfg_t        cfg;

  int               duty_now;
  logic             fan_on;
  logic             kick_armed;
  logic [TimeW-1:0] kick_start;
  logic             seq_on;
  logic [TimeW-1:0] seq_start;

  task automatic report_mismatch(input string msg);
    if (fail_count_o < 40) $display("%0t: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic int clamp_duty(input int v, input int lo, input int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic fan_result_t predict_fan_step(input logic cmd, input logic [TimeW-1:0] now,
                                                   input logic signed [TempW-1:0] temp,
                                                   input logic rv);
    int               t, tf, ton, toff, mn, mx;
    int               target, span, num, d, mag, q;
    logic [TimeW-1:0] el, kick_age;
    longint           ramp_num;
    fan_result_t      r;
    t    = temp;
    tf   = $signed(cfg.temp_full);
    ton  = $signed(cfg.temp_turn_on);
    toff = $signed(cfg.temp_turn_off);
    mn   = cfg.min_duty;
    mx   = cfg.max_duty;
    r.kicking = 1'b0;
    if (!cmd) begin
      seq_on     = 1'b1;
      seq_start  = now;
      duty_now   = 0;
      fan_on     = 1'b0;
      kick_armed = 1'b0;
    end else if (!rv || t < TempLowest || t > TempHighest) begin
      // a bad reading only forces the duty to zero once the power-on sequence is over
      if (!seq_on) duty_now = 0;
    end else begin
      el = now - seq_start;
      if (seq_on && el < SeqDelayMs) begin
        duty_now = 0;
      end else if (seq_on && el < SeqTotalMs) begin
        ramp_num = longint'(el - SeqDelayMs) * longint'(mx);
        duty_now = int'((2 * ramp_num + 10000) / 20000);
      end else begin
        if (seq_on) begin
          seq_on     = 1'b0;
          fan_on     = 1'b0;
          kick_armed = 1'b0;
        end
        if (t >= tf) begin
          target = mx;
        end else if (t <= toff) begin
          target = 0;
        end else if (t >= ton) begin
          span   = tf - ton;
          num    = t - ton;
          d      = mx - mn;
          mag    = d < 0 ? -d : d;
          q      = (2 * num * mag + span) / (2 * span);
          target = clamp_duty(mn + (d < 0 ? -q : q), mn, mx);
        end else begin
          // hysteresis band: run at minimum duty while running, stay off otherwise
          target = fan_on ? mn : 0;
        end
        if (target > 0 && !fan_on) begin
          fan_on     = 1'b1;
          kick_armed = 1'b1;
          kick_start = now;
        end else if (target == 0) begin
          fan_on     = 1'b0;
          kick_armed = 1'b0;
        end
        kick_age = now - kick_start;
        if (kick_armed && kick_age < TimeW'(cfg.kick_ms)) begin
          duty_now  = cfg.kick_duty;
          r.kicking = 1'b1;
        end else if (duty_now < target) begin
          duty_now = clamp_duty(duty_now + int'(cfg.slew_step), 0, target);
        end else if (duty_now > target) begin
          duty_now = clamp_duty(duty_now - int'(cfg.slew_step), target, mx);
        end
      end
    end
    r.duty        = duty_now[DutyW-1:0];
    r.fan_running = fan_on;
    r.powering_on = seq_on;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fan_result_t want;
    if (!rst_ni) begin
      cfg.temp_full     = CfgTempW'(960);
      cfg.temp_turn_on  = CfgTempW'(640);
      cfg.temp_turn_off = CfgTempW'(560);
      cfg.min_duty      = DutyW'(300);
      cfg.max_duty      = DutyW'(1023);
      cfg.kick_duty     = DutyW'(1023);
      cfg.kick_ms       = KickMsW'(500);
      cfg.slew_step     = SlewW'(5);
      duty_now          = 0;
      fan_on            = 1'b0;
      kick_armed        = 1'b0;
      kick_start        = '0;
      seq_on            = 1'b1;
      seq_start         = '0;
      duty_expected_q.delete();
      fail_count_o      = 0;
      pending_o         = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[ApbAddrW-1:2]))
          REG_TEMP_FULL:     cfg.temp_full     = pwdata_i[CfgTempW-1:0];
          REG_TEMP_TURN_ON:  cfg.temp_turn_on  = pwdata_i[CfgTempW-1:0];
          REG_TEMP_TURN_OFF: cfg.temp_turn_off = pwdata_i[CfgTempW-1:0];
          REG_MIN_DUTY:      cfg.min_duty      = pwdata_i[DutyW-1:0];
          REG_MAX_DUTY:      cfg.max_duty      = pwdata_i[DutyW-1:0];
          REG_KICK_DUTY:     cfg.kick_duty     = pwdata_i[DutyW-1:0];
          REG_KICK_MS:       cfg.kick_ms       = pwdata_i[KickMsW-1:0];
          REG_SLEW_STEP:     cfg.slew_step     = pwdata_i[SlewW-1:0];
          default: ;
        endcase
      end
      // compare before predicting so a stray result never meets a fresh expectation
      if (out_valid_i && out_ready_i) begin
        if (duty_expected_q.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = duty_expected_q.pop_front();
          if (duty_i !== want.duty)
            report_mismatch($sformatf("duty: got %0d want %0d", duty_i, want.duty));
          if (fan_running_i !== want.fan_running)
            report_mismatch($sformatf("fan_running: got %b want %b",
                                      fan_running_i, want.fan_running));
          if (kicking_i !== want.kicking)
            report_mismatch($sformatf("kicking: got %b want %b", kicking_i, want.kicking));
          if (powering_on_i !== want.powering_on)
            report_mismatch($sformatf("powering_on: got %b want %b",
                                      powering_on_i, want.powering_on));
        end
      end
      if (in_valid_i && in_ready_i)
        duty_expected_q.push_back(predict_fan_step(command_i, now_ms_i, temp_sixteenths_i,
                                                   reading_valid_i));
      pending_o = duty_expected_q.size();
    end
  end

endmodule

FILE: sim/fan_duty_controller_core_tb.sv
module fan_duty_controller_core_tb;
  import fdc_pkg::*;

  logic                    clk_i             = 1'b0;
  logic                    rst_ni            = 1'b0;
  logic                    psel              = 1'b0;
  logic                    penable           = 1'b0;
  logic                    pwrite            = 1'b0;
  logic [ApbAddrW-1:0]     paddr             = '0;
  logic [ApbDataW-1:0]     pwdata            = '0;
  logic [ApbDataW-1:0]     prdata;
  logic                    pready;
  logic                    in_valid_i        = 1'b0;
  logic                    in_ready_o;
  logic                    command_i         = 1'b0;
  logic [TimeW-1:0]        now_ms_i          = '0;
  logic signed [TempW-1:0] temp_sixteenths_i = '0;
  logic                    reading_valid_i   = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i       = 1'b0;
  logic [DutyW-1:0]        duty_o;
  logic                    fan_running_o;
  logic                    kicking_o;
  logic                    powering_on_o;

  int               fail_count;
  int               pending;
  int               sent_items = 0;
  bit               calm       = 1'b0;
  bit               hold_req   = 1'b0;
  int               hold_left  = 0;
  logic [TimeW-1:0] clock_ms;
  int               cur_tf     = 960;
  int               cur_ton    = 640;
  int               cur_toff   = 560;

  fan_duty_controller_core DUT (.*);

  fan_duty_checker duty_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .pready_i          (pready),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .command_i         (command_i),
    .now_ms_i          (now_ms_i),
    .temp_sixteenths_i (temp_sixteenths_i),
    .reading_valid_i   (reading_valid_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .duty_i            (duty_o),
    .fan_running_i     (fan_running_o),
    .kicking_i         (kicking_o),
    .powering_on_i     (powering_on_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #6_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random back-pressure, plus a long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 18);
      end
    end
  end

  task automatic send_reading(input logic cmd, input logic [TimeW-1:0] now, input int temp,
                              input logic rv);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    command_i         <= cmd;
    now_ms_i          <= now;
    temp_sixteenths_i <= TempW'(temp);
    reading_valid_i   <= rv;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input int tf, input int ton, input int toff, input int mn,
                               input int mx, input int kd, input int km, input int ss);
    write_reg(REG_TEMP_FULL, tf);
    write_reg(REG_TEMP_TURN_ON, ton);
    write_reg(REG_TEMP_TURN_OFF, toff);
    write_reg(REG_MIN_DUTY, mn);
    write_reg(REG_MAX_DUTY, mx);
    write_reg(REG_KICK_DUTY, kd);
    write_reg(REG_KICK_MS, km);
    write_reg(REG_SLEW_STEP, ss);
    cur_tf   = tf;
    cur_ton  = ton;
    cur_toff = toff;
  endtask

  task automatic random_setting();
    int ton, tf, toff, km;
    ton  = $urandom_range(2800) - 880;
    tf   = ton + $urandom_range(1, 2000 - ton);
    toff = ($urandom_range(3) == 0) ? $urandom_range(2880) - 880 : $urandom_range(ton + 880) - 880;
    km   = ($urandom_range(4) == 0) ? $urandom_range(65535) : $urandom_range(800);
    apply_setting(tf, ton, toff, $urandom_range(1023), $urandom_range(1, 1023),
                  $urandom_range(1023), km, $urandom_range(1, 255));
  endtask

  // drop valid and let every outstanding transaction drain
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic pick_reading(output int temp, output logic rv);
    int k;
    k    = $urandom_range(99);
    rv   = 1'b1;
    temp = $urandom_range(2880) - 880;
    if (k < 5) begin
      temp = $urandom_range(8191) - 4096;
      rv   = $urandom_range(1);
    end else if (k < 10) begin
      temp = $urandom_range(8191) - 4096;
      rv   = 1'b0;
    end else if (k < 15) begin
      temp = $urandom_range(1) ? -int'($urandom_range(881, 4096)) : $urandom_range(2001, 4095);
    end else if (k < 60) begin
      case ($urandom_range(2))
        0:       temp = cur_tf;
        1:       temp = cur_ton;
        default: temp = cur_toff;
      endcase
      temp = temp + $urandom_range(6) - 3;
    end
  endtask

  // one power-on run: restart, long steps through the ramp, then mostly short control steps
  task automatic run_session(input int updates);
    logic [TimeW-1:0] since;
    int               temp;
    int               k;
    logic             rv;
    clock_ms = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(20000) : $urandom();
    send_reading(1'b0, clock_ms, $urandom_range(8191) - 4096, $urandom_range(1));
    since = '0;
    for (int i = 0; i < updates; i++) begin
      k = $urandom_range(99);
      if (since < 16000)
        since = $urandom_range(300, 4000);
      else if (k < 60)
        since = $urandom_range(250);
      else if (k < 90)
        since = $urandom_range(250, 3000);
      else
        since = $urandom();
      clock_ms = clock_ms + since;
      since    = (since > 16000) ? since : since + 16000 * (i > 5);
      if ($urandom_range(19) == 0) begin
        send_reading($urandom_range(1), $urandom(), $urandom_range(8191) - 4096,
                     $urandom_range(1));
      end else begin
        pick_reading(temp, rv);
        send_reading(1'b1, clock_ms, temp, rv);
      end
    end
  endtask

  initial begin
    int goal;
    bit paused;
    paused = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // power-on from reset, ramp rounding, kick window, band, bad readings, wrap
    send_reading(1'b1, 100, 800, 1'b1);
    send_reading(1'b1, 200, 800, 1'b0);
    send_reading(1'b1, 300, -4096, 1'b1);
    send_reading(1'b1, 5000, 800, 1'b1);
    send_reading(1'b1, 7500, 800, 1'b1);
    send_reading(1'b1, 10000, 800, 1'b1);
    send_reading(1'b1, 14999, 800, 1'b1);
    send_reading(1'b1, 15000, 1000, 1'b1);
    send_reading(1'b1, 15400, 800, 1'b1);
    send_reading(1'b1, 15500, 800, 1'b1);
    send_reading(1'b1, 15600, 600, 1'b1);
    send_reading(1'b1, 15700, 4095, 1'b1);
    send_reading(1'b1, 15800, 2000, 1'b1);
    send_reading(1'b1, 15900, -880, 1'b1);
    send_reading(1'b1, 16000, 640, 1'b1);
    send_reading(1'b1, 16100, 959, 1'b0);
    send_reading(1'b1, 16200, 959, 1'b1);
    send_reading(1'b1, 16900, 700, 1'b1);
    send_reading(1'b1, 17000, 561, 1'b1);
    send_reading(1'b0, 32'hFFFF_F000, -4096, 1'b0);
    send_reading(1'b1, 32'h0000_0F00, 1200, 1'b1);
    send_reading(1'b1, 32'h0000_3000, 1200, 1'b1);
    send_reading(1'b1, 32'h0000_3001, 2001, 1'b1);
    send_reading(1'b1, 32'hFFFF_FFFF, -881, 1'b1);

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: apply_setting(960, 640, 560, 300, 1023, 1023, 500, 5);
        1: apply_setting(2000, -880, -880, 0, 1023, 0, 0, 255);
        2: apply_setting(-880, 2000, 2000, 1023, 1, 1023, 65535, 1);
        3: apply_setting(1500, 200, 100, 900, 100, 512, 300, 37);
        default: random_setting();
      endcase
      if (ph == 1) hold_req = 1'b1;
      calm = (ph == 4);
      goal = sent_items + 70;
      while (sent_items < goal) begin
        if (ph == 3 && !paused && sent_items > goal - 40) begin
          paused = 1'b1;
          in_valid_i <= 1'b0;
          wait (pending == 0);
          @(negedge clk_i);
        end
        run_session($urandom_range(6, 20));
      end
      calm = 1'b0;
    end

    drain();
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
